// ----- design/tpd_pkg.sv -----
// shared types and constants for the tablet packet decoder
// no dependencies; used by tpd_decode and tablet_packet_decoder_top
package tpd_pkg;

    // tablet type codes, a code not listed decodes as the 7-byte family
    localparam logic [2:0] TT_CROSS     = 3'd0;
    localparam logic [2:0] TT_NINE_BYTE = 3'd6;
    localparam logic [2:0] TT_RESET     = 3'd3;

    // record lengths in bytes
    localparam int REC_LEN_CROSS = 5;
    localparam int REC_LEN_SEVEN = 7;
    localparam int REC_LEN_NINE  = 9;

    // bytes the decoder looks at
    localparam int DEC_BYTES = 9;

    // nine-byte packet kinds, matched on byte 0
    localparam logic [7:0] ID_MASK  = 8'hfc;
    localparam logic [7:0] ID_CODE  = 8'hc0;
    localparam logic [7:0] OOP_MASK = 8'hfe;
    localparam logic [7:0] OOP_CODE = 8'h80;
    localparam logic [7:0] PEN_MASK = 8'hb8;
    localparam logic [7:0] PEN_CODE = 8'ha0;

    // stylus tip id, anything else counts as the eraser end
    localparam logic [10:0] TIP_TOOL_ID = 11'h022;

    // pen pressure: raw 10-bit value offset by 512, button 0 at raw >= 32
    localparam logic [9:0] PRESS_BTN_RAW = 10'd32;
    // 7-byte pressure lift when the range bit is clear
    localparam logic [9:0] PRESS_LIFT    = 10'd127;

    localparam int RES_W     = 49;
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_PAD_W = OUT_TDATA_W - RES_W;

    typedef logic [DEC_BYTES-1:0][7:0] record_view_t;
    typedef logic [1:0][11:0] tool_id_t;

    // first member sits in the top bits, is_puck ends up at bit 0
    typedef struct packed {
        logic              eraser;
        logic signed [9:0] pressure;
        logic              touching;
        logic [3:0]        button_bits;
        logic [15:0]       raw_y;
        logic [15:0]       raw_x;
        logic              is_puck;
    } result_t;

    typedef struct packed {
        logic        we;
        logic        tool;
        logic [11:0] word;
    } id_update_t;

endpackage

// ----- design/tablet_packet_decoder_top.sv -----
// top level of the tablet packet decoder: byte register, record framing, result register
// depends on tpd_pkg and tpd_decode
//
// takes one serial byte per word on the slave stream and gives one decoded tablet event per
// word on the master stream. while hunting, bytes with bit 7 clear are dropped; a byte with
// bit 7 set opens a record of 5 (cross), 9 (nine-byte tool-id type) or 7 (all other types)
// bytes, and the bytes after it are taken whatever their bit 7. a complete record gives one
// event, except nine-byte id, out-of-proximity and unknown packets, which give none; an id
// packet stores the tool's id word used for the eraser flag. rate: one byte per clock cycle,
// sustained, as long as the master side takes results. an accepted byte sits in the byte
// register until the result register has room, and then framing and field decode load any
// event into the result register. while a result waits, the byte register still takes the
// next byte, and the slave side then stalls. writing tablet_type drops any partial record and
// returns to hunting; stored id words are kept. write it only while the block is idle.
module tablet_packet_decoder_top #(
    parameter int MAX_RECORD_BYTES = 9
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration: tablet_type
    input  logic                              cfg_wr_en,
    input  logic [2:0]                        cfg_wr_data,
    // input stream, tdata: rx_byte [7:0]
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,
    // output stream, tdata: is_puck [0], raw_x [16:1], raw_y [32:17],
    // button_bits [36:33], touching [37], pressure [47:38], eraser [48], zero [55:49]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [tpd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    localparam int IDX_W = $clog2(MAX_RECORD_BYTES);

    // configuration
    logic [2:0]              tablet_type_reg;

    // byte register
    logic                    in_valid_reg;
    logic [7:0]              in_byte_reg;

    // framing state
    logic                    in_record_reg;
    logic [IDX_W-1:0]        byte_count_reg;
    logic [7:0]              rec_store_reg [MAX_RECORD_BYTES];
    tpd_pkg::tool_id_t       tool_id_reg;

    // result register
    logic                    out_valid_reg;
    tpd_pkg::result_t        out_res_reg;

    // framing and decode
    logic                    advance;
    logic                    take;
    logic [IDX_W-1:0]        rec_idx;
    logic [IDX_W-1:0]        last_idx;
    logic                    rec_done;
    tpd_pkg::record_view_t   rec_view;
    logic                    dec_emit;
    tpd_pkg::result_t        dec_res;
    tpd_pkg::id_update_t     dec_id_upd;

    // the byte register moves on when the result register has room
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // a byte counts while inside a record, or when it opens one
    assign take    = in_record_reg || in_byte_reg[7];
    assign rec_idx = in_record_reg ? byte_count_reg : '0;

    always_comb
    begin
        case (tablet_type_reg)
            tpd_pkg::TT_CROSS:     last_idx = IDX_W'(tpd_pkg::REC_LEN_CROSS - 1);
            tpd_pkg::TT_NINE_BYTE: last_idx = IDX_W'(tpd_pkg::REC_LEN_NINE - 1);
            default:               last_idx = IDX_W'(tpd_pkg::REC_LEN_SEVEN - 1);
        endcase
    end

    assign rec_done = take && (rec_idx == last_idx);

    // the last byte of a record comes straight from the byte register
    always_comb
    begin
        for (int i = 0; i < tpd_pkg::DEC_BYTES; i++)
        begin
            rec_view[i] = (rec_idx == IDX_W'(i)) ? in_byte_reg : rec_store_reg[i];
        end
    end

    tpd_decode u_decode (
        .tablet_type (tablet_type_reg),
        .rec         (rec_view),
        .tool_id     (tool_id_reg),
        .emit        (dec_emit),
        .res         (dec_res),
        .id_upd      (dec_id_upd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tablet_type_reg <= tpd_pkg::TT_RESET;
            in_valid_reg    <= 1'b0;
            in_record_reg   <= 1'b0;
            byte_count_reg  <= '0;
            tool_id_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            // byte register
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end

            // result register loads a new event, else drains when taken
            if (!cfg_wr_en && advance && rec_done && dec_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tvalid && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_wr_en)
            begin
                // new tablet type, back to hunting
                tablet_type_reg <= cfg_wr_data;
                in_record_reg   <= 1'b0;
                byte_count_reg  <= '0;
            end
            else if (advance && take)
            begin
                if (rec_done)
                begin
                    in_record_reg  <= 1'b0;
                    byte_count_reg <= '0;
                    if (dec_id_upd.we)
                    begin
                        tool_id_reg[dec_id_upd.tool] <= dec_id_upd.word;
                    end
                end
                else
                begin
                    in_record_reg  <= 1'b1;
                    byte_count_reg <= rec_idx + 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (advance && take && !rec_done)
        begin
            rec_store_reg[rec_idx] <= in_byte_reg;
        end
        if (advance && rec_done && dec_emit)
        begin
            out_res_reg <= dec_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{tpd_pkg::OUT_PAD_W{1'b0}}, out_res_reg};

`ifndef SYNTHESIS
    // inside a record the count sits between the opening byte and the last byte
    assert property (@(posedge clk) disable iff (!rst_n)
        in_record_reg |-> (byte_count_reg != '0) && (byte_count_reg <= last_idx))
        else $error("byte count out of record range");

    // hunting always restarts from the first slot
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_record_reg |-> (byte_count_reg == '0))
        else $error("byte count not cleared while hunting");

    // id words change only for the nine-byte type
    assert property (@(posedge clk) disable iff (!rst_n)
        (tablet_type_reg != tpd_pkg::TT_NINE_BYTE) |=> $stable(tool_id_reg))
        else $error("tool id word written outside nine-byte mode");

    // a result appears only when a byte moved through framing
    assert property (@(posedge clk) disable iff (!rst_n)
        (!advance && !out_valid_reg) |=> !out_valid_reg)
        else $error("result without a framed byte");
`endif

endmodule

// ----- design/tpd_decode.sv -----
// field decode of one complete tablet record
// depends on tpd_pkg for the record view, result and id update types
module tpd_decode (
    input  logic [2:0]           tablet_type,
    input  tpd_pkg::record_view_t rec,
    input  tpd_pkg::tool_id_t    tool_id,
    output logic                 emit,
    output tpd_pkg::result_t     res,
    output tpd_pkg::id_update_t  id_upd
);

    logic [7:0] b0, b1, b2, b3, b4, b5, b6;
    logic       tool;
    logic [9:0] press_raw;
    logic [9:0] press_seven;

    assign b0 = rec[0];
    assign b1 = rec[1];
    assign b2 = rec[2];
    assign b3 = rec[3];
    assign b4 = rec[4];
    assign b5 = rec[5];
    assign b6 = rec[6];

    assign tool        = b0[0];
    assign press_raw   = {b5[2:0], b6[6:0]};
    assign press_seven = {3'd0, b6[5:0], b3[2]} + (b6[6] ? 10'd0 : tpd_pkg::PRESS_LIFT);

    always_comb
    begin
        emit   = 1'b0;
        res    = '0;
        id_upd = '0;
        unique case (tablet_type)
            tpd_pkg::TT_CROSS:
            begin
                emit            = 1'b1;
                res.raw_x       = {2'd0, b2[6:0], b1[6:0]};
                res.raw_y       = {2'd0, b4[6:0], b3[6:0]};
                res.button_bits = {2'd0, b0[1:0]};
                res.touching    = b0[5];
            end
            tpd_pkg::TT_NINE_BYTE:
            begin
                res.eraser = (tool_id[tool][10:0] != tpd_pkg::TIP_TOOL_ID);
                if ((b0 & tpd_pkg::ID_MASK) == tpd_pkg::ID_CODE)
                begin
                    id_upd.we   = 1'b1;
                    id_upd.tool = tool;
                    id_upd.word = {b1[6:0], b2[6:2]};
                end
                else if ((b0 & tpd_pkg::OOP_MASK) == tpd_pkg::OOP_CODE)
                begin
                    emit = 1'b0;  // tool left proximity
                end
                else if ((b0 & tpd_pkg::PEN_MASK) == tpd_pkg::PEN_CODE)
                begin
                    emit            = 1'b1;
                    res.raw_x       = {b1[6:0], b2[6:0], b3[6:5]};
                    res.raw_y       = {b3[4:0], b4[6:0], b5[6:3]};
                    // raw - 512 in ten bits is a flip of the top bit
                    res.pressure    = {~press_raw[9], press_raw[8:0]};
                    res.button_bits = {1'b0, b0[2:1], press_raw >= tpd_pkg::PRESS_BTN_RAW};
                    res.touching    = b0[6];
                end
            end
            default:
            begin
                emit            = 1'b1;
                res.is_puck     = ~b0[5];
                res.raw_x       = {2'd0, b1[6:0], b2[6:0]};
                res.raw_y       = {2'd0, b4[6:0], b5[6:0]};
                res.button_bits = b3[6:3];
                res.touching    = b0[6];
                res.pressure    = press_seven;
            end
        endcase
    end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// testbench for tablet_packet_decoder_top: byte stream in, decoded tablet events out
// depends on tpd_pkg and the design files, event prediction is built in below

module tb_top;

    localparam int CLK_HIGH_NS   = 4;
    localparam int CLK_LOW_NS    = 4;
    localparam int RESET_CYCLES  = 6;
    // settling margin, waited out before any register write
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_GUARD   = 20000;
    localparam int RUN_LIMIT_NS  = 4_000_000;
    localparam int RANDOM_BYTES  = 1100;
    localparam int PHASES        = 10;
    localparam int PRINT_CAP     = 100;

    // tablet types without a name in the package
    localparam logic [2:0] TT_LCD   = 3'd1;
    localparam logic [2:0] TT_TINY  = 3'd2;
    localparam logic [2:0] TT_MULTI = 3'd3;
    localparam logic [2:0] TT_LARGE = 3'd4;
    localparam logic [2:0] TT_SMALL = 3'd5;
    localparam logic [2:0] TT_SPARE = 3'd7;

    typedef enum int {KIND_ID, KIND_OUT, KIND_PEN, KIND_OTHER} pkt_kind_t;
    typedef logic [7:0] byte_seq_t [$];

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_wr_en;
    logic [2:0]                      cfg_wr_data;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [7:0]                      s_axis_tdata;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [tpd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    tablet_packet_decoder_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #CLK_LOW_NS clk = 1'b1;
        #CLK_HIGH_NS clk = 1'b0;
    end

    // decoder state as the testbench sees it
    logic [2:0]  cur_type;
    logic [7:0]  rec_bytes [0:tpd_pkg::DEC_BYTES-1];
    int          rec_fill;
    bit          rec_open;
    logic [11:0] id_word [0:1];

    tpd_pkg::result_t pending_events [$];
    int               err_count = 0;
    int               burst_left = 0;

    tpd_pkg::result_t seen_ev;
    tpd_pkg::result_t want_ev;

    // receiver stall pattern
    logic [15:0] ready_mask;
    int          ready_pos = 0;

    function automatic int record_length(input logic [2:0] t);
        if (t == tpd_pkg::TT_CROSS)
            return tpd_pkg::REC_LEN_CROSS;
        if (t == tpd_pkg::TT_NINE_BYTE)
            return tpd_pkg::REC_LEN_NINE;
        return tpd_pkg::REC_LEN_SEVEN;
    endfunction

    // decode the gathered record, returns 1 when it gives an event
    function automatic bit decode_record(output tpd_pkg::result_t ev);
        logic [9:0] raw;
        logic       tool;
        ev = '0;
        if (cur_type == tpd_pkg::TT_CROSS)
        begin
            ev.raw_x       = {2'b00, rec_bytes[2][6:0], rec_bytes[1][6:0]};
            ev.raw_y       = {2'b00, rec_bytes[4][6:0], rec_bytes[3][6:0]};
            ev.button_bits = {2'b00, rec_bytes[0][1:0]};
            ev.touching    = rec_bytes[0][5];
            return 1'b1;
        end
        if (cur_type == tpd_pkg::TT_NINE_BYTE)
        begin
            tool      = rec_bytes[0][0];
            // eraser uses the id word stored before this record
            ev.eraser = (id_word[tool][10:0] != tpd_pkg::TIP_TOOL_ID);
            if ((rec_bytes[0] & tpd_pkg::ID_MASK) == tpd_pkg::ID_CODE)
            begin
                id_word[tool] = {rec_bytes[1][6:0], rec_bytes[2][6:2]};
                return 1'b0;
            end
            if ((rec_bytes[0] & tpd_pkg::OOP_MASK) == tpd_pkg::OOP_CODE)
                return 1'b0;
            if ((rec_bytes[0] & tpd_pkg::PEN_MASK) != tpd_pkg::PEN_CODE)
                return 1'b0;
            ev.raw_x       = {rec_bytes[1][6:0], rec_bytes[2][6:0], rec_bytes[3][6:5]};
            ev.raw_y       = {rec_bytes[3][4:0], rec_bytes[4][6:0], rec_bytes[5][6:3]};
            raw            = {rec_bytes[5][2:0], rec_bytes[6][6:0]};
            ev.pressure    = raw - 10'd512;
            ev.button_bits = {1'b0, rec_bytes[0][2:1], raw >= tpd_pkg::PRESS_BTN_RAW};
            ev.touching    = rec_bytes[0][6];
            return 1'b1;
        end
        // 7-byte family, the spare type code included
        ev.is_puck     = ~rec_bytes[0][5];
        ev.raw_x       = {2'b00, rec_bytes[1][6:0], rec_bytes[2][6:0]};
        ev.raw_y       = {2'b00, rec_bytes[4][6:0], rec_bytes[5][6:0]};
        ev.button_bits = rec_bytes[3][6:3];
        ev.touching    = rec_bytes[0][6];
        ev.pressure    = {3'b000, rec_bytes[6][5:0], rec_bytes[3][2]}
                         + (rec_bytes[6][6] ? 10'd0 : tpd_pkg::PRESS_LIFT);
        return 1'b1;
    endfunction

    // framing: hunt for bit 7, gather a record, decode it when full
    function automatic bit take_byte(input logic [7:0] v, output tpd_pkg::result_t ev);
        ev = '0;
        if (!rec_open)
        begin
            if (!v[7])
                return 1'b0;
            rec_open = 1'b1;
            rec_fill = 0;
        end
        rec_bytes[rec_fill] = v;
        rec_fill++;
        if (rec_fill < record_length(cur_type))
            return 1'b0;
        rec_open = 1'b0;
        rec_fill = 0;
        return decode_record(ev);
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        err_count++;
        if (err_count <= PRINT_CAP)
            $display("%0t tb_top mismatch %s: got %0h want %0h", $time, what, got, want);
    endtask

    task automatic compare_event(input tpd_pkg::result_t got, input tpd_pkg::result_t want,
                                 input logic [tpd_pkg::OUT_PAD_W-1:0] pad);
        if (got.is_puck !== want.is_puck)
            report_mismatch("is_puck", 16'(got.is_puck), 16'(want.is_puck));
        if (got.raw_x !== want.raw_x)
            report_mismatch("raw_x", got.raw_x, want.raw_x);
        if (got.raw_y !== want.raw_y)
            report_mismatch("raw_y", got.raw_y, want.raw_y);
        if (got.button_bits !== want.button_bits)
            report_mismatch("button_bits", 16'(got.button_bits), 16'(want.button_bits));
        if (got.touching !== want.touching)
            report_mismatch("touching", 16'(got.touching), 16'(want.touching));
        if (got.pressure !== want.pressure)
            report_mismatch("pressure", 16'(got.pressure), 16'(want.pressure));
        if (got.eraser !== want.eraser)
            report_mismatch("eraser", 16'(got.eraser), 16'(want.eraser));
        if (pad !== '0)
            report_mismatch("pad bits", 16'(pad), 16'h0);
    endtask

    // result checker, every accepted word against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen_ev = tpd_pkg::result_t'(m_axis_tdata[tpd_pkg::RES_W-1:0]);
            if (pending_events.size() == 0)
                report_mismatch("unexpected event x", seen_ev.raw_x, 16'h0);
            else
            begin
                want_ev = pending_events.pop_front();
                compare_event(seen_ev, want_ev,
                              m_axis_tdata[tpd_pkg::OUT_TDATA_W-1:tpd_pkg::RES_W]);
            end
        end
    end

    // receiver: a 16-bit ready pattern, reloaded in one of four modes
    always @(negedge clk)
    begin
        if (ready_pos == 0)
        begin
            case ($urandom_range(0, 3))
                0: ready_mask = 16'hffff;
                1: ready_mask = 16'($urandom | $urandom);
                2: ready_mask = 16'($urandom);
                default: ready_mask = 16'h3333;
            endcase
        end
        m_axis_tready <= ready_mask[ready_pos];
        ready_pos = (ready_pos + 1) % 16;
    end

    // one byte over the slave stream; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] v);
        int               gap;
        tpd_pkg::result_t ev;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (take_byte(v, ev))
            pending_events.push_back(ev);
        burst_left--;
        @(negedge clk);
    endtask

    task automatic send_seq(input byte_seq_t seq);
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    // hold the sender until every predicted event has come out
    task automatic hold_for_events();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (pending_events.size() != 0 && guard < DRAIN_GUARD)
        begin
            @(negedge clk);
            guard++;
        end
        @(negedge clk);
    endtask

    // idle point: nothing pending, pipeline flushed
    task automatic wait_drained();
        hold_for_events();
        if (pending_events.size() != 0)
        begin
            report_mismatch("events never seen", 16'h0, 16'(pending_events.size()));
            pending_events.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // register write, only called at an idle point
    task automatic write_tablet_type(input logic [2:0] t);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= t;
        @(posedge clk);
        cur_type = t;
        rec_open = 1'b0;
        rec_fill = 0;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // a well-formed record for the current type with random content
    function automatic byte_seq_t random_record();
        byte_seq_t  seq;
        logic [7:0] b0;
        logic [7:0] r;
        pkt_kind_t  kind;
        int         n;
        int         pick;
        n  = record_length(cur_type);
        b0 = 8'h80 | 8'($urandom_range(0, 127));
        if (cur_type == tpd_pkg::TT_NINE_BYTE)
        begin
            pick = $urandom_range(0, 9);
            kind = (pick < 3) ? KIND_ID : (pick == 3) ? KIND_OUT :
                   (pick == 4) ? KIND_OTHER : KIND_PEN;
            case (kind)
                KIND_ID:  b0 = tpd_pkg::ID_CODE | 8'($urandom_range(0, 3));
                KIND_OUT: b0 = tpd_pkg::OOP_CODE | 8'($urandom_range(0, 1));
                KIND_PEN: b0 = tpd_pkg::PEN_CODE | (8'($urandom) & 8'h47);
                default:
                begin
                    do
                        b0 = 8'h80 | 8'($urandom_range(0, 127));
                    while (((b0 & tpd_pkg::ID_MASK) == tpd_pkg::ID_CODE)
                           || ((b0 & tpd_pkg::OOP_MASK) == tpd_pkg::OOP_CODE)
                           || ((b0 & tpd_pkg::PEN_MASK) == tpd_pkg::PEN_CODE));
                end
            endcase
            seq.push_back(b0);
            // half the id packets carry the tip id, so eraser goes both ways
            if (kind == KIND_ID && $urandom_range(0, 1) == 1)
            begin
                r = 8'($urandom);
                seq.push_back({r[7], 7'h01});
                seq.push_back({r[6], 5'h02, r[1:0]});
            end
        end
        else
            seq.push_back(b0);
        while (seq.size() < n)
            seq.push_back(8'($urandom_range(0, 255)));
        return seq;
    endfunction

    // reset type is multi mode, so the first records go out without a write
    task automatic test_seven_byte_layouts();
        send_seq('{8'h00, 8'h7f});
        send_seq('{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff});
        send_seq('{8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        // range bit clear, pressure lifted
        send_seq('{8'hc0, 8'h7f, 8'h00, 8'h7b, 8'h00, 8'h7f, 8'h3f});
        wait_drained();
        // spare type code decodes as multi mode
        write_tablet_type(TT_SPARE);
        send_seq('{8'ha0, 8'h55, 8'h2a, 8'h44, 8'h33, 8'h11, 8'h40});
        wait_drained();
        write_tablet_type(TT_LCD);
        send_seq('{8'h9f, 8'h81, 8'hfe, 8'h04, 8'h01, 8'h80, 8'h00});
        wait_drained();
    endtask

    task automatic test_cross_layout();
        write_tablet_type(tpd_pkg::TT_CROSS);
        send_seq('{8'h12, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff});
        send_seq('{8'h80, 8'h00, 8'h00, 8'h00, 8'h00});
        send_seq('{8'ha3, 8'h12, 8'h34, 8'h56, 8'h78});
        wait_drained();
    endtask

    task automatic test_nine_byte_packets();
        write_tablet_type(tpd_pkg::TT_NINE_BYTE);
        // pen before any id: eraser, top pressure
        send_seq('{8'ha0, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h00, 8'h00});
        // tip id for tool 0
        send_seq('{8'hc0, 8'h01, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        // tool 0 tip, pressure one below the button threshold
        send_seq('{8'ha6, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h1f, 8'h00, 8'h00});
        // tool 1 still without id, pressure at the threshold
        send_seq('{8'he1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h20, 8'h00, 8'h00});
        // out of proximity and an unknown packet give nothing
        send_seq('{8'h81, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f});
        send_seq('{8'h90, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08});
        wait_drained();
    endtask

    task automatic test_partial_record_dropped();
        send_seq('{8'h85, 8'h11, 8'h22});
        wait_drained();
        // the write throws away the three bytes above
        write_tablet_type(tpd_pkg::TT_CROSS);
        send_seq('{8'h82, 8'h01, 8'h02, 8'h03, 8'h04});
        wait_drained();
    endtask

    task automatic test_random_traffic();
        logic [2:0] plan [0:PHASES-1];
        byte_seq_t  rec;
        byte_seq_t  part;
        int         sent;
        int         hold_at;
        bit         held;
        int         n;
        plan = '{tpd_pkg::TT_NINE_BYTE, tpd_pkg::TT_CROSS, TT_MULTI, TT_LCD,
                 tpd_pkg::TT_NINE_BYTE, TT_SPARE, TT_TINY, TT_LARGE, TT_SMALL,
                 tpd_pkg::TT_NINE_BYTE};
        for (int p = 0; p < PHASES; p++)
        begin
            write_tablet_type(plan[p]);
            sent    = 0;
            held    = 1'b0;
            hold_at = $urandom_range(20, 90);
            while (sent < RANDOM_BYTES / PHASES)
            begin
                // noise while hunting, ignored by the block
                if (!rec_open && $urandom_range(0, 6) == 0)
                    repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 127)));
                rec = random_record();
                send_seq(rec);
                sent += rec.size();
                if (!held && sent >= hold_at)
                begin
                    hold_for_events();
                    held = 1'b1;
                end
            end
            // now and then leave a record unfinished for the next write to drop
            if ($urandom_range(0, 2) == 0)
            begin
                part.delete();
                n = $urandom_range(1, record_length(cur_type) - 1);
                part.push_back(8'h80 | 8'($urandom_range(0, 127)));
                while (part.size() < n)
                    part.push_back(8'($urandom_range(0, 255)));
                send_seq(part);
            end
            wait_drained();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = tpd_pkg::TT_RESET;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        m_axis_tready = 1'b0;
        cur_type      = tpd_pkg::TT_RESET;
        rec_open      = 1'b0;
        rec_fill      = 0;
        id_word[0]    = '0;
        id_word[1]    = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        test_seven_byte_layouts();
        test_cross_layout();
        test_nine_byte_packets();
        test_partial_record_dropped();
        test_random_traffic();

        wait_drained();
        if (err_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // hang guard
    initial
    begin
        #RUN_LIMIT_NS;
        $display("tb_top: errors");
        $finish;
    end

endmodule
